@@ rtl/fir_decimator_complex_defines.svh @@
// Assertion macros for the checker file of the decimating filter.
`ifndef FIR_DECIMATOR_COMPLEX_DEFINES_SVH
`define FIR_DECIMATOR_COMPLEX_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/fdc_pkg.sv @@
package fdc_pkg;

    // Default sizes of the filter.
    localparam int FDC_TAPS         = 64;
    localparam int FDC_SAMPLE_WIDTH = 16;
    localparam int FDC_COEF_WIDTH   = 16;

    // Port field widths.
    localparam int VALUE_W      = 16;
    localparam int COEF_IDX_W   = 6;
    localparam int ACC_W        = 40;
    localparam int OUT_IDX_W    = 16;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 96;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    // Request kinds carried in tuser.
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

    // Control from the sequencer to the multiply-accumulate pipeline.
    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctl_t;

endpackage

@@ rtl/fdc_store.sv @@
module fdc_store
    import fdc_pkg::*;
#(
    parameter int TAPS         = FDC_TAPS,
    parameter int SAMPLE_WIDTH = FDC_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FDC_COEF_WIDTH,
    parameter int AW           = 6
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           hist_we,
    input  logic [AW-1:0]                  hist_waddr,
    input  logic signed [SAMPLE_WIDTH-1:0] hist_wre,
    input  logic signed [SAMPLE_WIDTH-1:0] hist_wim,
    input  logic [AW-1:0]                  hist_raddr,
    input  logic                           coef_we,
    input  logic [AW-1:0]                  coef_waddr,
    input  logic signed [COEF_WIDTH-1:0]   coef_wre,
    input  logic signed [COEF_WIDTH-1:0]   coef_wim,
    input  logic [AW-1:0]                  coef_raddr,
    output logic signed [SAMPLE_WIDTH-1:0] hist_rre,
    output logic signed [SAMPLE_WIDTH-1:0] hist_rim,
    output logic signed [COEF_WIDTH-1:0]   coef_rre,
    output logic signed [COEF_WIDTH-1:0]   coef_rim
);

    logic [2*SAMPLE_WIDTH-1:0] hist_mem [TAPS];
    logic [2*COEF_WIDTH-1:0]   coef_mem [TAPS];
    logic [TAPS-1:0]           coef_vld_reg;
    logic [2*SAMPLE_WIDTH-1:0] hist_rd_reg;
    logic [2*COEF_WIDTH-1:0]   coef_rd_reg;
    logic                      coef_rd_vld_reg;

    // Sample history: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= {hist_wim, hist_wre};
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // Coefficient store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= {coef_wim, coef_wre};
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    // A tap never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            coef_rd_vld_reg <= coef_vld_reg[coef_raddr];
        end
    end

    assign hist_rre = hist_rd_reg[SAMPLE_WIDTH-1:0];
    assign hist_rim = hist_rd_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign coef_rre = coef_rd_vld_reg ? coef_rd_reg[COEF_WIDTH-1:0] : '0;
    assign coef_rim = coef_rd_vld_reg ? coef_rd_reg[2*COEF_WIDTH-1:COEF_WIDTH] : '0;

endmodule

@@ rtl/fdc_mac.sv @@
module fdc_mac
    import fdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = FDC_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FDC_COEF_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mac_ctl_t                       ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] x_re,
    input  logic signed [SAMPLE_WIDTH-1:0] x_im,
    input  logic signed [COEF_WIDTH-1:0]   h_re,
    input  logic signed [COEF_WIDTH-1:0]   h_im,
    output logic                           busy,
    output logic signed [ACC_W-1:0]        acc_re,
    output logic signed [ACC_W-1:0]        acc_im
);

    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;

    logic                   rd_v_reg;
    logic                   mul_v_reg;
    logic signed [PW-1:0]   p_rr_reg;
    logic signed [PW-1:0]   p_ii_reg;
    logic signed [PW-1:0]   p_ri_reg;
    logic signed [PW-1:0]   p_ir_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [ACC_W-1:0] acc_re_next;
    logic signed [ACC_W-1:0] acc_im_next;

    // Valid flags follow each tap through memory read and multiply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= ctl.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    // Four partial products of the complex multiply, registered.
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            p_rr_reg <= x_re * h_re;
            p_ii_reg <= x_im * h_im;
            p_ri_reg <= x_re * h_im;
            p_ir_reg <= x_im * h_re;
        end
    end

    // Wrapping accumulation at the output width.
    always_comb
    begin
        acc_re_next = acc_re_reg + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
        acc_im_next = acc_im_reg + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (mul_v_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign busy   = rd_v_reg | mul_v_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

@@ rtl/fdc_ctrl.sv @@
module fdc_ctrl
    import fdc_pkg::*;
#(
    parameter int TAPS = FDC_TAPS,
    parameter int AW   = 6,
    parameter int FW   = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [COEF_IDX_W-1:0] coef_index,
    input  logic                  last_of_frame,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  hist_we,
    output logic [AW-1:0]         hist_waddr,
    output logic [AW-1:0]         hist_raddr,
    output logic                  coef_we,
    output logic [AW-1:0]         coef_waddr,
    output logic [AW-1:0]         coef_raddr,
    output mac_ctl_t              mac_ctl,
    input  logic                  mac_busy,
    input  logic                  out_free,
    output logic                  out_load,
    output logic [OUT_IDX_W-1:0]  out_index
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [8:0]    TAPS_9  = 9'(TAPS);
    localparam logic [FW-1:0] TAPS_F  = FW'(TAPS);
    localparam logic [AW-1:0] LAST_A  = AW'(TAPS - 1);

    logic [1:0]           state_reg, state_next;
    logic [8:0]           dec_reg, dec_next;
    logic [6:0]           taps_reg, taps_next;
    logic [5:0]           zoff_reg, zoff_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        wptr_reg, wptr_next;
    logic [7:0]           skip_reg, skip_next;
    logic [OUT_IDX_W-1:0] ocnt_reg, ocnt_next;
    logic [OUT_IDX_W-1:0] oidx_reg, oidx_next;
    logic [FW-1:0]        n_reg, n_next;
    logic [FW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        rptr_reg, rptr_next;

    logic                 accept;
    logic [7:0]           skip_cur;
    logic [7:0]           m_minus1;
    logic [FW-1:0]        fill_inc;
    logic [8:0]           taps_eff;
    logic [8:0]           n_wide;

    // Per-sample arithmetic on the frame counters.
    always_comb
    begin
        skip_cur = (fill_reg == '0) ? 8'(zoff_reg) : skip_reg;
        if (dec_reg == '0)
        begin
            m_minus1 = 8'd0;
        end
        else if (dec_reg[8])
        begin
            m_minus1 = 8'd255;
        end
        else
        begin
            m_minus1 = dec_reg[7:0] - 8'd1;
        end
        fill_inc = (fill_reg == TAPS_F) ? fill_reg : fill_reg + FW'(1);
        taps_eff = ({2'b0, taps_reg} > TAPS_9) ? TAPS_9 : {2'b0, taps_reg};
        n_wide   = (taps_eff > 9'(fill_inc)) ? 9'(fill_inc) : taps_eff;
    end

    assign accept = in_valid && in_ready;

    // Sequencer and configuration registers.
    always_comb
    begin
        state_next  = state_reg;
        dec_next    = dec_reg;
        taps_next   = taps_reg;
        zoff_next   = zoff_reg;
        fill_next   = fill_reg;
        wptr_next   = wptr_reg;
        skip_next   = skip_reg;
        ocnt_next   = ocnt_reg;
        oidx_next   = oidx_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        rptr_next   = rptr_reg;
        hist_we     = 1'b0;
        coef_we     = 1'b0;
        mac_ctl     = '0;
        out_load    = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DECIM:  dec_next  = cfg_data;
                REG_TAPS:   taps_next = cfg_data[6:0];
                REG_OFFSET: zoff_next = cfg_data[5:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_COEF)
                begin
                    coef_we = ({3'b0, coef_index} < TAPS_9);
                end
                else if (accept)
                begin
                    hist_we   = 1'b1;
                    wptr_next = (wptr_reg == LAST_A) ? '0 : wptr_reg + AW'(1);
                    fill_next = last_of_frame ? '0 : fill_inc;
                    if (skip_cur == '0)
                    begin
                        oidx_next     = ocnt_reg;
                        ocnt_next     = last_of_frame ? '0 : ocnt_reg + OUT_IDX_W'(1);
                        skip_next     = m_minus1;
                        n_next        = FW'(n_wide);
                        cnt_next      = '0;
                        rptr_next     = wptr_reg;
                        mac_ctl.clear = 1'b1;
                        state_next    = (n_wide == '0) ? ST_DRAIN : ST_RUN;
                    end
                    else
                    begin
                        skip_next = skip_cur - 8'd1;
                        ocnt_next = last_of_frame ? '0 : ocnt_reg;
                    end
                end
            end
            ST_RUN:
            begin
                mac_ctl.issue = 1'b1;
                cnt_next      = cnt_reg + FW'(1);
                rptr_next     = (rptr_reg == '0) ? LAST_A : rptr_reg - AW'(1);
                if (cnt_next == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_reg   <= 9'd1;
            taps_reg  <= 7'd1;
            zoff_reg  <= '0;
            fill_reg  <= '0;
            wptr_reg  <= '0;
            skip_reg  <= '0;
            ocnt_reg  <= '0;
            n_reg     <= '0;
            cnt_reg   <= '0;
            rptr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dec_reg   <= dec_next;
            taps_reg  <= taps_next;
            zoff_reg  <= zoff_next;
            fill_reg  <= fill_next;
            wptr_reg  <= wptr_next;
            skip_reg  <= skip_next;
            ocnt_reg  <= ocnt_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            rptr_reg  <= rptr_next;
        end
    end

    // Output number travels with the result, no reset needed.
    always_ff @(posedge clk)
    begin
        oidx_reg <= oidx_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign hist_waddr = wptr_reg;
    assign hist_raddr = rptr_reg;
    assign coef_waddr = AW'(coef_index);
    assign coef_raddr = cnt_reg[AW-1:0];
    assign out_index  = oidx_reg;

endmodule

@@ rtl/fir_decimator_complex.sv @@
// Channel | Dir | Handshake               | Contents
// s       | in  | s_tvalid / s_tready     | coefficient write or sample, tlast ends frame
// m       | out | m_tvalid / m_tready     | filtered complex output and its number
// cfg     | in  | cfg_valid / cfg_ready   | register index and write data
//
// A coefficient item, or a sample that yields no output, leaves the input open.
// A sample that yields an output keeps the input closed from its acceptance until
// its result is loaded. It uses n taps, at most the tap count and the samples in
// the frame: the single complex multiply-accumulate pipeline reads one tap
// per cycle from the history and coefficient memories, then drains and loads
// the result once the output register is free to take it. Reset clears
// the taps through per-entry valid bits, so no clearing pass is needed. A
// stalled m channel holds one result while the next item is taken; a second
// result waits for it.
module fir_decimator_complex
    import fdc_pkg::*;
#(
    parameter int TAPS         = FDC_TAPS,
    parameter int SAMPLE_WIDTH = FDC_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = FDC_COEF_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coef_index [5:0], value_re [21:6], value_im [37:22], zero pad [39:38]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type [0]
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_re [39:0], out_im [79:40], out_index [95:80]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW = $clog2(TAPS + 1);

    logic [VALUE_W-1:0]             value_re;
    logic [VALUE_W-1:0]             value_im;
    logic                           hist_we;
    logic [AW-1:0]                  hist_waddr;
    logic [AW-1:0]                  hist_raddr;
    logic                           coef_we;
    logic [AW-1:0]                  coef_waddr;
    logic [AW-1:0]                  coef_raddr;
    logic signed [SAMPLE_WIDTH-1:0] hist_rre;
    logic signed [SAMPLE_WIDTH-1:0] hist_rim;
    logic signed [COEF_WIDTH-1:0]   coef_rre;
    logic signed [COEF_WIDTH-1:0]   coef_rim;
    mac_ctl_t                       mac_ctl;
    logic                           mac_busy;
    logic signed [ACC_W-1:0]        acc_re;
    logic signed [ACC_W-1:0]        acc_im;
    logic                           out_free;
    logic                           out_load;
    logic [OUT_IDX_W-1:0]           out_index;
    logic                           m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]         m_tdata_reg;

    assign value_re  = s_tdata[COEF_IDX_W +: VALUE_W];
    assign value_im  = s_tdata[COEF_IDX_W + VALUE_W +: VALUE_W];
    assign cfg_ready = 1'b1;

    fdc_ctrl #(
        .TAPS (TAPS),
        .AW   (AW),
        .FW   (FW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .req_type      (s_tuser),
        .coef_index    (s_tdata[COEF_IDX_W-1:0]),
        .last_of_frame (s_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .hist_we       (hist_we),
        .hist_waddr    (hist_waddr),
        .hist_raddr    (hist_raddr),
        .coef_we       (coef_we),
        .coef_waddr    (coef_waddr),
        .coef_raddr    (coef_raddr),
        .mac_ctl       (mac_ctl),
        .mac_busy      (mac_busy),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_index     (out_index)
    );

    fdc_store #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .AW           (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wre   (SAMPLE_WIDTH'(value_re)),
        .hist_wim   (SAMPLE_WIDTH'(value_im)),
        .hist_raddr (hist_raddr),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wre   (COEF_WIDTH'(value_re)),
        .coef_wim   (COEF_WIDTH'(value_im)),
        .coef_raddr (coef_raddr),
        .hist_rre   (hist_rre),
        .hist_rim   (hist_rim),
        .coef_rre   (coef_rre),
        .coef_rim   (coef_rim)
    );

    fdc_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .x_re   (hist_rre),
        .x_im   (hist_rim),
        .h_re   (coef_rre),
        .h_im   (coef_rim),
        .busy   (mac_busy),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // Output register: holds one result while the engine moves on.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {out_index, acc_im, acc_re};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/fdc_checker.sv @@
`include "fir_decimator_complex_defines.svh"

module fdc_assert
    import fdc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic m_stall;
    logic coef_acc;

    assign m_stall  = m_tvalid && !m_tready;
    assign coef_acc = s_tvalid && s_tready && (s_tuser == REQ_COEF);

    // A result waiting on a stalled consumer stays put.
    `FDC_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // A coefficient write never stalls the input.
    `FDC_ASSERT_NEXT(a_coef_one_cycle, coef_acc, s_tready, "coefficient item stalled input")

    // A new result only appears after the filter has been busy computing it.
    `FDC_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result without work")

endmodule

bind fir_decimator_complex fdc_assert u_fdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
